// File: hw/rtl/mwsd_pkg.sv
// Package for the Melbourne-Wubbena cycle slip detector.
// Holds the payload structs, default parameters and fixed constants.
// No dependencies.
package mwsd_pkg;

  localparam int NumSatsDefault   = 64;
  localparam int CountBitsDefault = 16;

  localparam int TimeW = 40;
  localparam int MwW   = 40;
  localparam int VarW  = 64;
  localparam int GapW  = 32;

  localparam logic [GapW-1:0] GapDefault = 32'd61000;
  localparam logic [VarW-1:0] VarRestart = 64'h0000_0000_1000_0000;

  localparam logic [1:0] SysUnknown = 2'd3;

  typedef struct packed {
    logic [5:0]              sat_index;
    logic [1:0]              sat_system;
    logic [TimeW-1:0]        epoch_ms;
    logic                    mw_present;
    logic signed [MwW-1:0]   mw_value;
    logic [2:0]              lli_first;
    logic [2:0]              lli_second;
    logic                    prior_slip;
  } in_t;

  typedef struct packed {
    logic slip_flag;
    logic drop_sat;
    logic system_error;
  } out_t;

endpackage

// File: hw/rtl/mw_cycle_slip_detector_core.sv
// Top level of the Melbourne-Wubbena cycle slip detector.
// Depends on mwsd_pkg, mwsd_ram and mwsd_serdiv.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one satellite
// observation per transfer. The output channel (out_valid_o, out_stall_i,
// out_data_o) gives exactly one result per observation, in order.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// gap limit in milliseconds; it is always ready, and a write of zero stores
// the default of 61000. Write it only while the block is idle.
// An observation with no value, an unknown system or an out-of-range slot
// goes straight to the result. A first sighting or a slip seen from the lock
// codes or the gap restarts its slot. Otherwise a bit-serial multiplier squares
// the bias (saturated at magnitudes of 2^32 and up); a square above the
// threshold is a slip, else two bit-serial dividers in parallel update mean and
// variance. One observation is in work at a time; in_stall_o is high while it is.
// The result sits in an output register; if the receiver stalls, the next
// observation may still be accepted and finishes once that register frees.
// Reset clears the seen marks of all slots and restores the gap limit.
module mw_cycle_slip_detector_core #(
  parameter int NUM_SATS   = mwsd_pkg::NumSatsDefault,
  parameter int COUNT_BITS = mwsd_pkg::CountBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  mwsd_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mwsd_pkg::out_t           out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [mwsd_pkg::GapW-1:0] cfg_data_i
);

  localparam int IdxW  = NUM_SATS > 1 ? $clog2(NUM_SATS) : 1;
  localparam int TimeW = mwsd_pkg::TimeW;
  localparam int MwW   = mwsd_pkg::MwW;
  localparam int VarW  = mwsd_pkg::VarW;
  localparam int WordW = TimeW + MwW + VarW + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  mwsd_pkg::in_t           item_q, item_d;
  mwsd_pkg::out_t          res_q, res_d;
  mwsd_pkg::out_t          out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic [mwsd_pkg::GapW-1:0] gap_lim_q, gap_lim_d;
  logic [NUM_SATS-1:0]     seen_q, seen_d;
  logic                    slip_q, slip_d;
  logic                    neg_q, neg_d;
  logic                    ge_q, ge_d;
  logic [MwW:0]            mag_q, mag_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VarW-1:0]         acc_q, acc_d;
  logic [VarW-1:0]         mcand_q, mcand_d;
  logic [31:0]             mplier_q, mplier_d;
  logic [4:0]              mcnt_q, mcnt_d;
  logic [VarW-1:0]         vdiff_q, vdiff_d;

  logic [IdxW-1:0]         idx;
  logic [WordW-1:0]        rdata, wdata;
  logic                    we;
  logic [TimeW-1:0]        rd_time;
  logic signed [MwW-1:0]   rd_mean;
  logic [VarW-1:0]         rd_var;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic                    seen;
  logic [TimeW:0]          gap;
  logic signed [MwW:0]     bias;
  logic                    slip0;
  logic [VarW-1:0]         thr;
  logic                    div_start;
  logic                    div1_done, div2_done;
  logic [MwW:0]            quot1;
  logic [VarW-1:0]         quot2;
  logic [MwW-1:0]          new_mean;
  logic [VarW-1:0]         new_var;
  logic                    restart;

  assign idx     = item_q.sat_index[IdxW-1:0];
  assign rd_time = rdata[WordW-1 -: TimeW];
  assign rd_mean = rdata[WordW-TimeW-1 -: MwW];
  assign rd_var  = rdata[COUNT_BITS +: VarW];
  assign rd_cnt  = rdata[COUNT_BITS-1:0];
  assign seen    = seen_q[idx];
  assign restart = (cnt_q == CountOne);

  mwsd_ram #(
    .Width(WordW),
    .Depth(NUM_SATS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(idx),
    .wdata_i(wdata),
    .raddr_i(idx),
    .rdata_o(rdata)
  );

  mwsd_serdiv #(
    .DivW(MwW + 1),
    .DsrW(COUNT_BITS)
  ) u_div_mean (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_q),
    .divisor_i (cnt_q),
    .done_o    (div1_done),
    .quot_o    (quot1)
  );

  mwsd_serdiv #(
    .DivW(VarW),
    .DsrW(COUNT_BITS)
  ) u_div_var (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(vdiff_d),
    .divisor_i (cnt_q),
    .done_o    (div2_done),
    .quot_o    (quot2)
  );

  always_comb begin
    gap   = {1'b0, item_q.epoch_ms} - {1'b0, rd_time};
    bias  = seen ? ({item_q.mw_value[MwW-1], item_q.mw_value} - {rd_mean[MwW-1], rd_mean})
                 : '0;
    slip0 = !seen || item_q.lli_first[0] || item_q.lli_second[0] ||
            (!gap[TimeW] && (gap[TimeW-1:0] > {{(TimeW-mwsd_pkg::GapW){1'b0}}, gap_lim_q}));
    thr   = (rd_var[VarW-1 -: 4] != 4'd0) ? '1 : {rd_var[VarW-5:0], 4'd0};
    new_mean = neg_q ? MwW'(rd_mean - quot1[MwW-1:0]) : MwW'(rd_mean + quot1[MwW-1:0]);
    new_var  = ge_q ? (rd_var + quot2) : (rd_var - quot2);
    wdata = restart ? {item_q.epoch_ms, item_q.mw_value, mwsd_pkg::VarRestart, cnt_q}
                    : {item_q.epoch_ms, new_mean, new_var, cnt_q};
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    gap_lim_d   = gap_lim_q;
    seen_d      = seen_q;
    slip_d      = slip_q;
    neg_d       = neg_q;
    ge_d        = ge_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    mcnt_d      = mcnt_q;
    vdiff_d     = vdiff_q;
    we          = 1'b0;
    div_start   = 1'b0;

    if (cfg_valid_i) begin
      gap_lim_d = (cfg_data_i == '0) ? mwsd_pkg::GapDefault : cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          if (!in_data_i.mw_present) begin
            res_d.drop_sat = 1'b1;
            state_d = S_DONE;
          end else if (in_data_i.sat_system == mwsd_pkg::SysUnknown) begin
            res_d.system_error = 1'b1;
            state_d = S_DONE;
          end else if (32'(in_data_i.sat_index) >= NUM_SATS) begin
            res_d.slip_flag = in_data_i.prior_slip;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        slip_d = slip0;
        neg_d  = bias[MwW];
        mag_d  = bias[MwW] ? (MwW+1)'(-bias) : bias;
        if (slip0) begin
          cnt_d   = CountOne;
          state_d = S_WRITE;
        end else begin
          cnt_d = (rd_cnt == CountMax) ? CountMax : rd_cnt + CountOne;
          if (mag_d[MwW:32] != '0) begin
            acc_d   = '1;
            state_d = S_CHECK;
          end else begin
            acc_d    = '0;
            mcand_d  = VarW'(mag_d[31:0]);
            mplier_d = mag_d[31:0];
            mcnt_d   = '0;
            state_d  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[VarW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[31:1]};
        mcnt_d   = mcnt_q + 5'd1;
        if (mcnt_q == 5'd31) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (acc_q > thr) begin
          slip_d  = 1'b1;
          cnt_d   = CountOne;
          state_d = S_WRITE;
        end else begin
          ge_d      = (acc_q >= rd_var);
          vdiff_d   = (acc_q >= rd_var) ? (acc_q - rd_var) : (rd_var - acc_q);
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div1_done && div2_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        we          = 1'b1;
        seen_d[idx] = 1'b1;
        res_d       = '0;
        res_d.slip_flag = item_q.prior_slip | slip_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gap_lim_q   <= mwsd_pkg::GapDefault;
      seen_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      gap_lim_q   <= gap_lim_d;
      seen_q      <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    out_q    <= out_d;
    slip_q   <= slip_d;
    neg_q    <= neg_d;
    ge_q     <= ge_d;
    mag_q    <= mag_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    mcnt_q   <= mcnt_d;
    vdiff_q  <= vdiff_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: hw/rtl/mwsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/mwsd_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module mwsd_serdiv #(
  parameter int DivW = 64,
  parameter int DsrW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW:0]   rem_sh;
  logic [DsrW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, quo_q[DivW-1]};
    trial  = rem_sh - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DsrW]) begin
        rem_d = trial[DsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DsrW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = ~busy_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/mwsd_checker.sv
// Port-level checker for the cycle slip detector, bound to the top level.
// Depends on mwsd_pkg and mw_cycle_slip_detector_core.
module mwsd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input mwsd_pkg::in_t             in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input mwsd_pkg::out_t            out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [mwsd_pkg::GapW-1:0] cfg_data_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // At most one of the three result flags is set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.slip_flag, out_data_o.drop_sat,
                              out_data_o.system_error}))
    else $error("result flags conflict");

  // Only one observation is in work: an accepted transfer stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // A missing value accepted while the output is free yields a drop result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.mw_present && !out_valid_o
    |=> ##1 out_valid_o && out_data_o.drop_sat)
    else $error("missing value not dropped");

endmodule

bind mw_cycle_slip_detector_core mwsd_checker u_mwsd_checker (.*);

// File: bench/mw_cycle_slip_detector_core_tb.sv
// Testbench for mw_cycle_slip_detector_core: directed, gap-limit and randomized tests
// checked against an in-bench predictor of the per-slot slip statistics.
// Depends on mwsd_pkg and the detector RTL.
module mw_cycle_slip_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mwsd_pkg::*;

  localparam int NSats = 64;
  localparam longint unsigned CntMax = 65535;
  localparam logic [1:0] SysGps = 2'd0;
  localparam logic [1:0] SysGal = 2'd1;
  localparam logic [1:0] SysBds = 2'd2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GapW-1:0] cfg_data = '0;

  mw_cycle_slip_detector_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state.
  logic [GapW-1:0] gap_limit = GapDefault;
  bit seen[NSats];
  longint last_epoch[NSats];
  longint win_mean[NSats];
  longint unsigned win_var[NSats];
  longint unsigned win_cnt[NSats];

  out_t pending_results[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int slips = 0;
  bit quiet = 1'b0;

  longint trk_epoch[NSats];
  longint trk_mw[NSats];

  function automatic out_t predict_slip(in_t it);
    out_t r;
    int s;
    bit slip;
    longint mw, gap, bias;
    longint unsigned mag, sq, thr, cnt, v, q;
    r = '0;
    s = it.sat_index;
    if (!it.mw_present) begin
      r.drop_sat = 1'b1;
      return r;
    end
    if (it.sat_system == SysUnknown) begin
      r.system_error = 1'b1;
      return r;
    end
    mw = longint'(it.mw_value);
    slip = !seen[s];
    if (seen[s]) begin
      gap = longint'({24'd0, it.epoch_ms}) - last_epoch[s];
      if (gap > longint'({32'd0, gap_limit})) slip = 1'b1;
    end
    if (it.lli_first[0] || it.lli_second[0]) slip = 1'b1;
    bias = seen[s] ? mw - win_mean[s] : 0;
    mag = bias < 0 ? -bias : bias;
    sq = mag > 64'hFFFF_FFFF ? '1 : mag * mag;
    cnt = win_cnt[s];
    if (cnt < CntMax) cnt++;
    if (slip) cnt = 1;
    if (cnt > 1) begin
      v = win_var[s];
      thr = v > (64'hFFFF_FFFF_FFFF_FFFF >> 4) ? '1 : v << 4;
      if (sq > thr) begin
        slip = 1'b1;
        cnt = 1;
      end
    end
    if (cnt < 2) begin
      win_mean[s] = mw;
      win_var[s] = VarRestart;
    end else begin
      q = mag / cnt;
      win_mean[s] = bias < 0 ? win_mean[s] - longint'(q) : win_mean[s] + longint'(q);
      v = win_var[s];
      if (sq >= v) v = v + (sq - v) / cnt;
      else v = v - (v - sq) / cnt;
      win_var[s] = v;
    end
    win_cnt[s] = cnt;
    last_epoch[s] = longint'({24'd0, it.epoch_ms});
    seen[s] = 1'b1;
    r.slip_flag = it.prior_slip | slip;
    return r;
  endfunction

  function automatic in_t obs(int idx, logic [1:0] sys, longint ep, bit pres, longint mw,
                              int l1, int l2, bit prior);
    in_t it;
    it.sat_index = idx[5:0];
    it.sat_system = sys;
    it.epoch_ms = ep[39:0];
    it.mw_present = pres;
    it.mw_value = mw[39:0];
    it.lli_first = l1[2:0];
    it.lli_second = l2[2:0];
    it.prior_slip = prior;
    return it;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    errors++;
    $display("MISMATCH %s: got %0b, expected %0b at %0t", what, got, want, $realtime);
  endtask

  task automatic send_obs(in_t it);
    bit took;
    if (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk_i);
      took = !in_stall;
      @(posedge clk_i);
    end while (!took);
    pending_results.push_back(predict_slip(it));
    sent++;
  endtask

  task automatic write_gap_limit(logic [GapW-1:0] v);
    bit took;
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk_i);
      took = cfg_ready;
      @(posedge clk_i);
    end while (!took);
    cfg_valid <= 1'b0;
    gap_limit = (v == 0) ? GapDefault : v;
  endtask

  always @(posedge clk_i) out_stall <= !quiet && ($urandom_range(99) < 37);

  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1'b1, 1'b0);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.slip_flag) slips++;
        if (out_data.slip_flag !== want.slip_flag)
          report_mismatch("slip_flag", out_data.slip_flag, want.slip_flag);
        if (out_data.drop_sat !== want.drop_sat)
          report_mismatch("drop_sat", out_data.drop_sat, want.drop_sat);
        if (out_data.system_error !== want.system_error)
          report_mismatch("system_error", out_data.system_error, want.system_error);
      end
    end
  end

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd549755813887;
    mn = -64'sd549755813888;
    send_obs(obs(0, SysGps, 0, 1, 0, 0, 0, 0));
    send_obs(obs(0, SysGps, 1000, 1, 100, 0, 0, 0));
    send_obs(obs(0, SysGal, 2000, 1, 120, 0, 0, 0));
    send_obs(obs(0, SysGps, 3000, 1, mx, 0, 0, 0));
    send_obs(obs(0, SysBds, 4000, 1, mn, 0, 0, 0));
    send_obs(obs(0, SysGps, 3500, 1, mn, 0, 0, 0));
    send_obs(obs(0, SysGps, 3500 + 61000, 1, mn + 5, 0, 0, 0));
    send_obs(obs(0, SysGps, 3500 + 122001, 1, mn, 0, 0, 0));
    send_obs(obs(1, SysGps, 10, 0, 77, 1, 1, 1));
    send_obs(obs(1, SysUnknown, 10, 0, 77, 0, 0, 0));
    send_obs(obs(1, SysUnknown, 10, 1, 77, 0, 0, 1));
    send_obs(obs(2, SysBds, 50, 1, -300, 0, 0, 0));
    send_obs(obs(2, SysBds, 60, 1, -290, 1, 0, 0));
    send_obs(obs(2, SysBds, 70, 1, -295, 0, 1, 0));
    send_obs(obs(2, SysBds, 80, 1, -296, 6, 6, 0));
    send_obs(obs(2, SysBds, 90, 1, -296, 0, 0, 1));
    send_obs(obs(63, SysGal, 64'hFF_FFFF_FFFF, 1, mx, 7, 7, 1));
    send_obs(obs(63, SysGal, 64'hFF_FFFF_FFFF, 1, mx, 2, 4, 0));
  endtask

  task automatic test_gap_limits();
    write_gap_limit(32'd0);
    send_obs(obs(5, SysGps, 0, 1, 10, 0, 0, 0));
    send_obs(obs(5, SysGps, 61001, 1, 10, 0, 0, 0));
    write_gap_limit(32'd1);
    send_obs(obs(5, SysGps, 61002, 1, 10, 0, 0, 0));
    send_obs(obs(5, SysGps, 61004, 1, 10, 0, 0, 0));
    write_gap_limit(32'hFFFF_FFFF);
    send_obs(obs(5, SysGps, 64'h1_0000_F000, 1, 10, 0, 0, 0));
    send_obs(obs(5, SysGps, 64'h1_0000_F000 + 64'hFFFF_FFFF, 1, 11, 0, 0, 0));
    write_gap_limit($urandom_range(5000, 90000));
  endtask

  task automatic random_track_obs(int n, int nslots);
    int s, kind;
    longint ep, mw;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(nslots - 1);
      kind = $urandom_range(99);
      ep = trk_epoch[s] + (kind < 6 ? $urandom_range(60000, 150000) : $urandom_range(1, 20000));
      if (kind >= 6 && kind < 8) ep = trk_epoch[s] - $urandom_range(1, 5000);
      ep = ep & 64'hFF_FFFF_FFFF;
      trk_epoch[s] = ep;
      if (kind >= 8 && kind < 14) trk_mw[s] = longint'(signed'({$urandom, $urandom} >>> 24));
      mw = trk_mw[s] + $signed($urandom_range(0, 32767)) - 16384;
      send_obs(obs(s, logic'($urandom_range(99) < 95) ? 2'($urandom_range(2)) : SysUnknown,
                   ep, $urandom_range(99) < 96, mw,
                   $urandom_range(99) < 90 ? 2 * $urandom_range(3) : $urandom_range(7),
                   $urandom_range(99) < 94 ? 0 : $urandom_range(7),
                   $urandom_range(99) < 10));
    end
  endtask

  task automatic random_noise_obs(int n);
    in_t it;
    for (int i = 0; i < n; i++) begin
      it = in_t'(96'({$urandom, $urandom, $urandom}));
      send_obs(it);
    end
  endtask

  task automatic test_random();
    for (int s = 0; s < NSats; s++) begin
      trk_epoch[s] = {$urandom_range(255), $urandom} & 64'h7F_FFFF_FFFF;
      trk_mw[s] = longint'(signed'({$urandom, 32'd0} >>> 26));
    end
    random_track_obs(500, 8);
    quiet = 1'b1;
    random_track_obs(200, 64);
    quiet = 1'b0;
    write_gap_limit(GapDefault);
    random_track_obs(500, 16);
    random_noise_obs(300);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_gap_limits();
    test_random();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (150) @(posedge clk_i);
    $display("Covered %0d observations, %0d results checked, %0d with a slip flag,",
             sent, checked, slips);
    $display("over several gap limits including both extremes and the zero default.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
